// ----- rtl/sabc_pkg.sv -----
// Shared types and constants for the sprite alpha blend and clip unit.
`default_nettype none

package sabc_pkg;

    typedef logic [7:0]  chan_t;
    typedef logic [15:0] mix_sum_t;

    localparam int unsigned GAIN_W  = 9;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned SIZE_W  = 13;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_UNITY      = 9'd256;
    localparam logic [SIZE_W-1:0] WIDTH_DEFAULT   = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_DEFAULT  = 13'd480;

    localparam chan_t ALPHA_FULL = 8'hFF;
    localparam chan_t ALPHA_NONE = 8'h00;

endpackage

`default_nettype wire

// ----- rtl/sabc_blend_lane.sv -----
// One color channel of the blend: weighted sum register and exact divide by 255.
`default_nettype none

module sabc_blend_lane
    import sabc_pkg::*;
(
    input  wire   clk,
    input  wire   load,
    input  chan_t alpha,
    input  chan_t src,
    input  chan_t dst,
    output chan_t quo
);

    mix_sum_t   sum_reg;
    mix_sum_t   sum_next;
    chan_t      q_est;
    logic [8:0] rem_est;

    assign sum_next = 16'(src) * 16'(alpha) + 16'(dst) * 16'(ALPHA_FULL - alpha);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= sum_next;
        end
    end

    // n>>8 underestimates n/255 by at most one, and the remainder left over
    // stays below twice 255, so a single compare fixes the quotient.
    assign q_est   = sum_reg[15:8];
    assign rem_est = 9'(sum_reg[7:0]) + 9'(q_est);
    assign quo     = q_est + chan_t'(rem_est >= 9'(ALPHA_FULL));

endmodule

`default_nettype wire

// ----- rtl/sprite_alpha_blend_clip_unit.sv -----
// Throughput: one pixel per cycle when not stalled; the three pipeline stages advance
// whenever the stage ahead is empty or moving, so a stalled output holds its beat and
// loses nothing. Accepted pixel beats pass stage 1 and stage 2 into the output register.
// Reset: rst_n clears all stage valid bits and loads gain 256, screen 640 by 480.
// Configuration writes are taken in every cycle.
`default_nettype none

module sprite_alpha_blend_clip_unit
    import sabc_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [SIZE_W-1:0]     cfg_data,
    input  wire                  pixel_valid,
    output logic                 pixel_ready,
    input  wire signed [15:0]    pixel_x,
    input  wire signed [15:0]    pixel_y,
    input  wire [31:0]           source_argb,
    input  wire [23:0]           dest_rgb,
    output logic                 result_valid,
    input  wire                  result_ready,
    output logic                 write_enable,
    output logic [23:0]          blended_rgb
);

    logic [GAIN_W-1:0] gain_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    logic        adv1;
    logic        adv2;
    logic        adv3;

    // Stage 1: clip result and scaled alpha product.
    logic        v1_reg;
    logic        on1_reg;
    logic        on1_next;
    logic [15:0] prod1_reg;
    logic [15:0] prod1_next;
    logic [23:0] src1_reg;
    logic [23:0] dst1_reg;
    logic [GAIN_W-1:0] gain_eff;

    // Stage 2: write decision and per-channel weighted sums.
    logic        v2_reg;
    logic        we2_reg;
    logic        full2_reg;
    logic [23:0] src2_reg;
    logic [23:0] dst2_reg;
    chan_t       alpha1;

    // Stage 3: output register.
    logic        v3_reg;
    logic        we3_reg;
    logic [23:0] rgb3_reg;
    logic [23:0] rgb3_next;
    chan_t       q_r;
    chan_t       q_g;
    chan_t       q_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_UNITY;
            width_reg  <= WIDTH_DEFAULT;
            height_reg <= HEIGHT_DEFAULT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ALPHA_GAIN:    gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign adv3 = !v3_reg || result_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign pixel_ready = adv1;

    // Gains above unity saturate to unity.
    assign gain_eff = gain_reg[GAIN_W-1] ? GAIN_UNITY : gain_reg;

    assign on1_next = !pixel_x[COORD_W-1] && !pixel_y[COORD_W-1]
                   && (16'(pixel_x[COORD_W-2:0]) < 16'(width_reg))
                   && (16'(pixel_y[COORD_W-2:0]) < 16'(height_reg));

    // Product peaks at 255*256+128, which still fits 16 bits.
    assign prod1_next = 16'(17'(source_argb[31:24]) * 17'(gain_eff) + 17'd128);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= pixel_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            on1_reg   <= on1_next;
            prod1_reg <= prod1_next;
            src1_reg  <= source_argb[23:0];
            dst1_reg  <= dest_rgb;
        end
    end

    assign alpha1 = prod1_reg[15:8];

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            we2_reg   <= on1_reg && (alpha1 != ALPHA_NONE);
            full2_reg <= (alpha1 == ALPHA_FULL);
            src2_reg  <= src1_reg;
            dst2_reg  <= dst1_reg;
        end
    end

    sabc_blend_lane u_lane_r (
        .clk   (clk),
        .load  (adv2),
        .alpha (alpha1),
        .src   (src1_reg[23:16]),
        .dst   (dst1_reg[23:16]),
        .quo   (q_r)
    );

    sabc_blend_lane u_lane_g (
        .clk   (clk),
        .load  (adv2),
        .alpha (alpha1),
        .src   (src1_reg[15:8]),
        .dst   (dst1_reg[15:8]),
        .quo   (q_g)
    );

    sabc_blend_lane u_lane_b (
        .clk   (clk),
        .load  (adv2),
        .alpha (alpha1),
        .src   (src1_reg[7:0]),
        .dst   (dst1_reg[7:0]),
        .quo   (q_b)
    );

    always_comb
    begin
        priority if (!we2_reg)
        begin
            rgb3_next = dst2_reg;
        end
        else if (full2_reg)
        begin
            rgb3_next = src2_reg;
        end
        else
        begin
            rgb3_next = {q_r, q_g, q_b};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            we3_reg  <= we2_reg;
            rgb3_reg <= rgb3_next;
        end
    end

    assign result_valid = v3_reg;
    assign write_enable = we3_reg;
    assign blended_rgb  = rgb3_reg;

endmodule

`default_nettype wire

// ----- rtl/sabc_checker.sv -----
// Port-level checks for the sprite alpha blend and clip unit, bound to the top level.
`default_nettype none

module sabc_checker
(
    input wire                 clk,
    input wire                 rst_n,
    input wire                 cfg_valid,
    input wire                 cfg_ready,
    input wire                 pixel_valid,
    input wire                 pixel_ready,
    input wire                 result_valid,
    input wire                 result_ready,
    input wire                 write_enable,
    input wire [23:0]          blended_rgb
);

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(blended_rgb) && $stable(write_enable))
    else $error("result beat changed while stalled");

    // An open output lets every stage move, so the input side must be open too.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> pixel_ready)
    else $error("input stalled while output accepts");

    // With the output open throughout and no beat entering at the start, the pipeline drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_ready && !(pixel_valid && pixel_ready)) ##1 result_ready ##1 result_ready
            |=> !result_valid)
    else $error("result beat appeared from nowhere");

    // Register writes are never held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind sprite_alpha_blend_clip_unit sabc_checker u_sabc_checker (.*);

`default_nettype wire

// ----- tb/sprite_alpha_blend_clip_unit_test.sv -----
// Self-checking testbench for the sprite alpha blend and clip unit.
`default_nettype none

module sprite_alpha_blend_clip_unit_test;
    import sabc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned STUCK_LIMIT = 5000;
    localparam int unsigned ITEMS_PER_SETTING = 100;

    typedef struct packed {
        logic        we;
        logic [23:0] rgb;
    } blend_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        src;
        logic [23:0]        dst;
        logic               known;
        blend_t             result;
    } pixel_row_t;

    typedef struct packed {
        logic [SIZE_W-1:0] gain_word;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } setting_t;

    // Rows marked known carry a result that follows directly from the reset
    // registers; the others are left to the predictor.
    localparam pixel_row_t DIRECTED [15] = '{
        '{16'sd0,      16'sd0,      32'hFF123456, 24'hABCDEF, 1'b1, '{1'b1, 24'h123456}},
        '{-16'sd1,     16'sd0,      32'hFFFFFFFF, 24'h00FF00, 1'b1, '{1'b0, 24'h00FF00}},
        '{16'sd639,    16'sd479,    32'hFF0000FF, 24'h000000, 1'b1, '{1'b1, 24'h0000FF}},
        '{16'sd640,    16'sd0,      32'hFFFFFFFF, 24'h5A5A5A, 1'b1, '{1'b0, 24'h5A5A5A}},
        '{16'sd0,      16'sd480,    32'hFFFFFFFF, 24'hA5A5A5, 1'b1, '{1'b0, 24'hA5A5A5}},
        '{-16'sd32768, -16'sd32768, 32'hFF808080, 24'h010203, 1'b1, '{1'b0, 24'h010203}},
        '{16'sd32767,  16'sd32767,  32'hFF808080, 24'hFFFFFF, 1'b1, '{1'b0, 24'hFFFFFF}},
        '{16'sd5,      16'sd5,      32'h00FFFFFF, 24'h123456, 1'b1, '{1'b0, 24'h123456}},
        '{16'sd10,     16'sd20,     32'h80FF0000, 24'h0000FF, 1'b0, '{1'b0, 24'h000000}},
        '{16'sd11,     16'sd21,     32'h01FFFFFF, 24'h000000, 1'b0, '{1'b0, 24'h000000}},
        '{16'sd12,     16'sd22,     32'hFE00FF00, 24'hFF00FF, 1'b0, '{1'b0, 24'h000000}},
        '{16'sd100,    16'sd200,    32'hFFFFFFFF, 24'hFFFFFF, 1'b1, '{1'b1, 24'hFFFFFF}},
        '{16'sd0,      -16'sd1,     32'hFF000000, 24'h777777, 1'b1, '{1'b0, 24'h777777}},
        '{-16'sd32768, 16'sd0,      32'hFF000000, 24'h888888, 1'b1, '{1'b0, 24'h888888}},
        '{16'sd320,    16'sd240,    32'h7F00FF00, 24'hFF00FF, 1'b0, '{1'b0, 24'h000000}}
    };

    localparam setting_t SETTINGS_LIST [7] = '{
        '{13'd0,     13'd1,    13'd1},
        '{13'h1FF,   13'd8191, 13'd8191},
        '{13'd128,   13'd0,    13'd480},
        '{13'h1E80,  13'd4096, 13'd1},
        '{13'd255,   13'd640,  13'd480},
        '{13'd257,   13'd320,  13'd240},
        '{13'd256,   13'd17,   13'd4096}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0] cfg_data = '0;
    logic              pixel_valid = 1'b0;
    logic              pixel_ready;
    logic signed [15:0] pixel_x = '0;
    logic signed [15:0] pixel_y = '0;
    logic [31:0]       source_argb = '0;
    logic [23:0]       dest_rgb = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic              write_enable;
    logic [23:0]       blended_rgb;

    // Register copies kept by the predictor.
    logic [GAIN_W-1:0] gain_q = GAIN_UNITY;
    logic [SIZE_W-1:0] width_q = WIDTH_DEFAULT;
    logic [SIZE_W-1:0] height_q = HEIGHT_DEFAULT;

    blend_t blend_due_q [$];
    int unsigned send_idle_pct = 26;
    int unsigned recv_idle_pct = 63;
    logic        stall_start = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stuck_cycles = 0;
    int unsigned fail_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned writes_seen = 0;
    int unsigned settings_done = 0;

    sprite_alpha_blend_clip_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .source_argb  (source_argb),
        .dest_rgb     (dest_rgb),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .write_enable (write_enable),
        .blended_rgb  (blended_rgb)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic blend_t blend_predict(input logic signed [15:0] x,
                                             input logic signed [15:0] y,
                                             input logic [31:0] src,
                                             input logic [23:0] dst);
        blend_t      r;
        int          xi;
        int          yi;
        int unsigned gain;
        int unsigned a;
        int unsigned s_c;
        int unsigned d_c;
        xi = int'(x);
        yi = int'(y);
        r.we = 1'b0;
        r.rgb = dst;
        if (xi < 0 || yi < 0 || xi >= int'(width_q) || yi >= int'(height_q))
            return r;
        gain = 32'((gain_q > GAIN_UNITY) ? GAIN_UNITY : gain_q);
        a = (32'(src[31:24]) * gain + 128) >> 8;
        if (a == 0)
            return r;
        r.we = 1'b1;
        if (a >= 32'(ALPHA_FULL))
        begin
            r.rgb = src[23:0];
            return r;
        end
        for (int c = 0; c < 3; c++)
        begin
            s_c = 32'(src[8*c +: 8]);
            d_c = 32'(dst[8*c +: 8]);
            r.rgb[8*c +: 8] = 8'((s_c * a + d_c * (255 - a)) / 255);
        end
        return r;
    endfunction

    function automatic logic [15:0] rand_coord(input int unsigned bound);
        if ($urandom_range(9) < 8)
            return 16'(int'($urandom_range(bound + 3)) - 2);
        return 16'($urandom);
    endfunction

    // Leaves valid high after the beat so that a following item keeps it high.
    task automatic send_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic [31:0] src, input logic [23:0] dst,
                              input logic known, input blend_t typed_result);
        blend_t due;
        if ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        due = known ? typed_result : blend_predict(x, y, src, dst);
        pixel_valid <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        source_argb <= src;
        dest_rgb <= dst;
        do @(posedge clk); while (!pixel_ready);
        blend_due_q = {blend_due_q, due};
        pixels_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ALPHA_GAIN:    gain_q = data[GAIN_W-1:0];
            CFG_SCREEN_WIDTH:  width_q = data;
            CFG_SCREEN_HEIGHT: height_q = data;
            default: ;
        endcase
    endtask

    task automatic drain_results;
        pixel_valid <= 1'b0;
        while (blend_due_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Receiver: random back-pressure, a long hold-off on request, and the result check.
    always @(posedge clk)
    begin
        blend_t due;
        if (rst_n && result_valid && result_ready)
        begin
            if (blend_due_q.size() == 0)
            begin
                $error("result beat with no pixel outstanding");
                fail_count++;
            end
            else
            begin
                due = blend_due_q.pop_front();
                if (write_enable !== due.we)
                begin
                    $error("write_enable: expected %0d, got %0d", due.we, write_enable);
                    fail_count++;
                end
                if (blended_rgb !== due.rgb)
                begin
                    $error("blended_rgb: expected %06h, got %06h", due.rgb, blended_rgb);
                    fail_count++;
                end
                if (write_enable === 1'b1)
                    writes_seen++;
            end
        end
        if (stall_start)
            hold_left <= HOLD_OFF_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        result_ready <= rst_n && !stall_start && hold_left == 0 &&
                        ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((pixel_valid && pixel_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [7:0]  alpha;
        logic [31:0] src;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_pixel(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].src, DIRECTED[i].dst,
                       DIRECTED[i].known, DIRECTED[i].result);
        drain_results();

        foreach (SETTINGS_LIST[s])
        begin
            cfg_write(CFG_ALPHA_GAIN, SETTINGS_LIST[s].gain_word);
            cfg_write(CFG_SCREEN_WIDTH, SETTINGS_LIST[s].width);
            cfg_write(CFG_SCREEN_HEIGHT, SETTINGS_LIST[s].height);
            cfg_write(CFG_SPARE, 13'($urandom));
            cfg_valid <= 1'b0;
            settings_done++;

            if (s < 3)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 63;
            end
            else if (s < 5)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // With both sides free-running, hold the output back once so the
            // pipeline fills and pushes back on the pixel input.
            if (s == 5)
            begin
                stall_start <= 1'b1;
                @(posedge clk);
                stall_start <= 1'b0;
            end

            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                case ($urandom_range(9))
                    0, 1, 2: alpha = ALPHA_FULL;
                    3:       alpha = ALPHA_NONE;
                    4:       alpha = 8'h01;
                    5:       alpha = 8'hFE;
                    default: alpha = 8'($urandom);
                endcase
                src = {alpha, 24'($urandom)};
                send_pixel(rand_coord(32'(width_q)), rand_coord(32'(height_q)), src,
                           24'($urandom), 1'b0, '0);
            end
            drain_results();
        end

        $display("Sent %0d pixel beats across reset defaults and %0d register settings;",
                 pixels_sent, settings_done);
        $display("%0d results wrote to the screen, the rest were clipped or transparent.",
                 writes_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
